@@ design/elb_pkg.sv @@
// Package for the edge load-balancer table: payload structs, state codes,
// register indexes and controller/datapath command types. No dependencies.
package elb_pkg;

  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] MODE_HB = 2'd0;
  localparam logic [1:0] MODE_ACK = 2'd1;
  localparam logic [1:0] MODE_REQ = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_TH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_TH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [31:0] node_addr;
    logic [15:0] node_port;
    logic [7:0] client_count;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [31:0] target_addr;
    logic [15:0] target_port;
    logic probe_new;
    logic no_node;
    logic scale_up;
    logic scale_down;
    logic table_full;
    logic [4:0] active_count;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HB_ADD,
    ST_EVICT,
    ST_ACK_MUL,
    ST_ACK_WR,
    ST_PING,
    ST_DOWN,
    ST_REMOVE,
    ST_SUMMARY,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item, clear scan
    logic scan_step;   // visit slot at scan index
    logic scan_clr;    // restart scan index at 0
    logic add;         // register new node at slot n
    logic evict_step;  // compaction: visit slot, keep or drop
    logic evict_done;  // commit compaction count
    logic ack_mul;     // compute products
    logic ack_wr;      // write score/ack time
    logic ping_step;   // emit ping target and stamp
    logic remove_step; // shift one slot down
    logic remove_done;
    logic sum_load;    // build summary item
    logic out_load;    // mark output register valid
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic full;
    logic many;      // n > 1
    logic idle_all;
    logic rm_end;
    logic out_busy;  // output register full and stalled
  } dp_stat_t;

endpackage

@@ design/elb_ctrl.sv @@
// Controller FSM of the edge load-balancer table.
// Depends on elb_pkg; drives dp_cmd_t to elb_dp and reads dp_stat_t.
module elb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic [1:0] mode,
  input  elb_pkg::dp_stat_t stat,
  output elb_pkg::dp_cmd_t cmd,
  output logic busy
);
  import elb_pkg::*;

  state_t state, state_next;
  logic [1:0] md;
  logic ping_pend, ping_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      md <= MODE_HB;
      ping_pend <= 1'b0;
    end else begin
      state <= state_next;
      ping_pend <= ping_pend_next;
      if (in_fire) md <= mode;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ping_pend_next = ping_pend;
    unique case (state)
      ST_IDLE: if (in_fire) begin
        state_next = (mode == MODE_TICK) ? ST_PING : ST_SCAN;
        ping_pend_next = 1'b0;
      end
      ST_SCAN: if (stat.scan_end) begin
        unique case (md)
          MODE_HB: state_next = (stat.found || stat.full) ? ST_EVICT : ST_HB_ADD;
          MODE_ACK: state_next = stat.found ? ST_ACK_MUL : ST_SUMMARY;
          MODE_REQ: state_next = ST_SUMMARY;
          default: state_next = stat.idle_all && stat.many ? ST_REMOVE : ST_SUMMARY;
        endcase
      end
      ST_HB_ADD: state_next = ST_EVICT;
      ST_EVICT: if (stat.scan_end) state_next = ST_SUMMARY;
      ST_ACK_MUL: state_next = ST_ACK_WR;
      ST_ACK_WR: state_next = ST_SUMMARY;
      ST_PING: begin
        if (ping_pend) begin
          if (!stat.out_busy) ping_pend_next = 1'b0;
        end else if (stat.scan_end) begin
          state_next = ST_DOWN;
        end else if (!stat.out_busy) begin
          ping_pend_next = 1'b1;
        end
      end
      ST_DOWN: if (!ping_pend) state_next = ST_SCAN;
      ST_REMOVE: if (stat.rm_end) state_next = ST_SUMMARY;
      ST_SUMMARY: if (!stat.out_busy) state_next = ST_OUT;
      ST_OUT: if (!stat.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.load = in_fire;
      ST_SCAN: cmd.scan_step = !stat.scan_end;
      ST_HB_ADD: cmd.add = 1'b1;
      ST_EVICT: begin
        cmd.evict_step = !stat.scan_end;
        cmd.evict_done = stat.scan_end;
      end
      ST_ACK_MUL: cmd.ack_mul = 1'b1;
      ST_ACK_WR: cmd.ack_wr = 1'b1;
      ST_PING: begin
        if (ping_pend) cmd.out_load = !stat.out_busy;
        else if (stat.scan_end) cmd.scan_clr = 1'b1;
        else cmd.ping_step = !stat.out_busy;
      end
      ST_DOWN: cmd = '0;
      ST_REMOVE: begin
        cmd.remove_step = !stat.rm_end;
        cmd.remove_done = stat.rm_end;
      end
      ST_SUMMARY: cmd.sum_load = !stat.out_busy;
      ST_OUT: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

@@ design/elb_dp.sv @@
// Datapath of the edge load-balancer table: slot table, scan unit,
// score multipliers and output register. Depends on elb_pkg.
module elb_dp #(
  parameter int unsigned NODE_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  elb_pkg::in_item_t in_item,
  input  logic cfg_we,
  input  logic [elb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [elb_pkg::CFG_W-1:0] cfg_data,
  input  elb_pkg::dp_cmd_t cmd,
  output elb_pkg::dp_stat_t stat,
  output logic out_valid,
  input  logic out_stall,
  output elb_pkg::out_item_t out_item
);
  import elb_pkg::*;

  localparam int unsigned IW = $clog2(NODE_SLOTS);
  localparam int unsigned CW = $clog2(NODE_SLOTS + 1);

  logic [7:0] load_w, lat_w;
  logic [31:0] up_th, down_th, timeout;

  logic [31:0] sa [NODE_SLOTS];
  logic [15:0] sp [NODE_SLOTS];
  logic [31:0] ss [NODE_SLOTS];
  logic [31:0] spt [NODE_SLOTS];
  logic [31:0] sat [NODE_SLOTS];

  in_item_t it;
  logic [CW-1:0] n, idx, wr;
  logic found, idle_all;
  logic [IW-1:0] hit, best;
  logic [31:0] best_score;
  logic [15:0] p_load;
  logic [39:0] p_lat;
  logic [31:0] t_addr;
  logic [15:0] t_port;
  logic probe, full_f, down_f;
  out_item_t sum;

  logic [IW-1:0] ci;
  logic [31:0] age;
  logic [31:0] lat;
  logic [40:0] score_sum;

  assign ci = idx[IW-1:0];
  assign age = it.now_ms - sat[ci];
  assign lat = it.now_ms - spt[hit];
  assign score_sum = {25'd0, p_load} + {1'b0, p_lat};

  assign stat.scan_end = (idx >= n);
  assign stat.found = found;
  assign stat.full = (n == CW'(NODE_SLOTS));
  assign stat.many = (n > CW'(1));
  assign stat.idle_all = idle_all;
  assign stat.rm_end = down_f && (idx + CW'(1) >= n);
  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_w <= 8'd1;
      lat_w <= 8'd1;
      up_th <= 32'd1000;
      down_th <= 32'd100;
      timeout <= 32'd10000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LOAD_W: load_w <= cfg_data[7:0];
        REG_LAT_W: lat_w <= cfg_data[7:0];
        REG_UP_TH: up_th <= cfg_data;
        REG_DOWN_TH: down_th <= cfg_data;
        REG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      idx <= '0;
      wr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.load || cmd.scan_clr) idx <= '0;
      if (cmd.load) begin
        it <= in_item;
        found <= 1'b0;
        idle_all <= 1'b1;
        hit <= '0;
        best <= '0;
        best_score <= '1;
        t_addr <= '0;
        t_port <= '0;
        probe <= 1'b0;
        full_f <= 1'b0;
        down_f <= 1'b0;
        wr <= '0;
      end
      if (cmd.scan_step) begin
        idx <= idx + CW'(1);
        if (!found && sa[ci] == it.node_addr && sp[ci] == it.node_port) begin
          found <= 1'b1;
          hit <= ci;
        end
        if (idx == '0 || ss[ci] < best_score) begin
          best <= ci;
          best_score <= ss[ci];
        end
        if (!(ss[ci] < down_th)) idle_all <= 1'b0;
        if (it.mode == MODE_HB && idx + CW'(1) >= n) begin
          // next phase (add/evict) restarts the scan
        end
      end
      if (cmd.add) begin
        sa[n[IW-1:0]] <= it.node_addr;
        sp[n[IW-1:0]] <= it.node_port;
        ss[n[IW-1:0]] <= '0;
        spt[n[IW-1:0]] <= it.now_ms;
        sat[n[IW-1:0]] <= it.now_ms;
        n <= n + CW'(1);
        probe <= 1'b1;
        t_addr <= it.node_addr;
        t_port <= it.node_port;
        idx <= '0;
      end
      if (!cmd.add && it.mode == MODE_HB && cmd.scan_step && idx + CW'(1) >= n) begin
        if (!found && !(sa[ci] == it.node_addr && sp[ci] == it.node_port)
            && n == CW'(NODE_SLOTS))
          full_f <= 1'b1;
      end
      if (it.mode == MODE_HB && !cmd.scan_step && !cmd.add && !cmd.evict_step
          && !cmd.evict_done && idx >= n && !cmd.load && wr == '0 && !cmd.sum_load
          && !cmd.out_load) begin
        // heartbeat at scan end: restart index for the add/eviction pass
        idx <= '0;
        if (!found && n == CW'(NODE_SLOTS)) full_f <= 1'b1;
      end
      if (cmd.evict_step) begin
        idx <= idx + CW'(1);
        if (!(age > timeout)) begin
          sa[wr[IW-1:0]] <= sa[ci];
          sp[wr[IW-1:0]] <= sp[ci];
          ss[wr[IW-1:0]] <= ss[ci];
          spt[wr[IW-1:0]] <= spt[ci];
          sat[wr[IW-1:0]] <= sat[ci];
          wr <= wr + CW'(1);
        end
      end
      if (cmd.evict_done) begin
        n <= wr;
      end
      if (cmd.ack_mul) begin
        p_load <= load_w * it.client_count;
        p_lat <= lat_w * lat;
      end
      if (cmd.ack_wr) begin
        ss[hit] <= score_sum[40:32] != '0 ? 32'hFFFF_FFFF : score_sum[31:0];
        sat[hit] <= it.now_ms;
      end
      if (cmd.ping_step) begin
        spt[ci] <= it.now_ms;
        idx <= idx + CW'(1);
        out_item <= '{kind: 1'b1, target_addr: sa[ci], target_port: sp[ci],
                      probe_new: 1'b0, no_node: 1'b0, scale_up: 1'b0,
                      scale_down: 1'b0, table_full: 1'b0,
                      active_count: 5'(n), last: 1'b0};
      end
      if (cmd.remove_step || cmd.remove_done) begin
        if (!down_f) begin
          down_f <= 1'b1;
          t_addr <= sa[best];
          t_port <= sp[best];
          idx <= CW'(best);
        end else if (cmd.remove_step) begin
          sa[ci] <= sa[ci + IW'(1)];
          sp[ci] <= sp[ci + IW'(1)];
          ss[ci] <= ss[ci + IW'(1)];
          spt[ci] <= spt[ci + IW'(1)];
          sat[ci] <= sat[ci + IW'(1)];
          idx <= idx + CW'(1);
        end
        if (down_f && cmd.remove_done) begin
          n <= n - CW'(1);
          idx <= n;
        end
      end
      if (cmd.sum_load) begin
        out_item <= sum;
      end
      if (cmd.out_load) out_valid <= 1'b1;
    end
  end

  always_comb begin
    sum = '0;
    sum.active_count = 5'(n);
    sum.last = 1'b1;
    unique case (it.mode)
      MODE_HB: begin
        sum.target_addr = t_addr;
        sum.target_port = t_port;
        sum.probe_new = probe;
        sum.table_full = full_f;
      end
      MODE_ACK: ;
      MODE_REQ: begin
        if (n == '0) sum.no_node = 1'b1;
        else begin
          sum.target_addr = sa[best];
          sum.target_port = sp[best];
          sum.scale_up = (best_score >= up_th);
        end
      end
      default: begin
        sum.target_addr = t_addr;
        sum.target_port = t_port;
        sum.scale_down = down_f;
      end
    endcase
  end
endmodule

@@ design/edge_load_balancer_table_top.sv @@
// Top level of the edge load-balancer table; instantiates elb_ctrl and
// elb_dp, depends on elb_pkg.
//   channel  direction  handshake
//   in       input      in_valid / in_stall, payload in_data
//   out      output     out_valid / out_stall, payload out_data
//   cfg      input      cfg_we, cfg_index, cfg_data
// One event at a time, set by the one-slot-a-cycle table scan: a request
// scans; an ack rescores a found node; a heartbeat may add, then evicts;
// a tick pings each node, rescans and may remove one. Output stalls lengthen events.
// Reset clears the live-node count; slot contents are written on registration.
// The output register holds each result until it is taken; the next one waits.
module edge_load_balancer_table_top #(
  parameter int unsigned NODE_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  elb_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output elb_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [elb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [elb_pkg::CFG_W-1:0] cfg_data
);
  import elb_pkg::*;

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic busy;
  logic in_fire;

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  elb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .mode(in_data.mode),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  elb_dp #(.NODE_SLOTS(NODE_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_data)
  );
endmodule
